[src/stereo_box_decimator_to_pcm16_macros.svh]
// Assertion macros shared by the decimator modules.
`ifndef STEREO_BOX_DECIMATOR_TO_PCM16_MACROS_SVH
`define STEREO_BOX_DECIMATOR_TO_PCM16_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define SBD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SBD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbd assertion failed");

`else

`define SBD_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SBD_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

[src/sbd_pkg.sv]
package sbd_pkg;

  // Default width of one input sample.
  localparam int SampleBitsDef = 24;

  // Window credit arithmetic.
  localparam int CreditW = 17;
  localparam logic [CreditW-1:0] OutRateC  = CreditW'(16000);
  localparam logic [CreditW-1:0] RateLowC  = CreditW'(44100);
  localparam logic [CreditW-1:0] RateHighC = CreditW'(48000);
  // The credit never reaches the out rate plus the highest input rate.
  localparam logic [CreditW-1:0] CreditLimitC = CreditW'(64000);

  // Frame count and divisor widths.
  localparam int CountW   = 3;
  localparam int SamplesW = 3;
  localparam logic [CountW-1:0] CountMaxC = CountW'(3);

  // Scaling by 32767 is done as (x << 15) - x.
  localparam int FullScaleShift = 15;
  // Width of the scaled magnitude that enters the divider.
  localparam int QuotW = 19;

  // Output format.
  localparam int PcmW = 16;
  localparam logic [PcmW-1:0] PcmMaxC = 16'h7FFF;
  localparam logic [PcmW-1:0] PcmMinC = 16'h8000;

  // Configuration port.
  localparam int PaddrW = 3;
  localparam int PdataW = 32;
  localparam logic RegRateSelect   = 1'b0;
  localparam logic RegStereoEnable = 1'b1;

  typedef struct packed {
    logic rate_select;
    logic stereo_enable;
  } sbd_cfg_t;

  // A window that closed: divisor of the average.
  typedef struct packed {
    logic                valid;
    logic [SamplesW-1:0] samples;
  } sbd_close_t;

endpackage

[src/stereo_box_decimator_to_pcm16.sv]
// Stereo box-filter decimator from 44.1 or 48 kHz frames to 16 kHz signed 16-bit PCM.
// Each accepted frame is added to the open window; a credit counter that restarts at
// every block end decides when a window closes, and then the average is scaled to
// int16 (truncated toward zero, saturated) by a bit-serial divider. A frame that
// closes no window adds no stall of its own. A frame that closes a window keeps the
// input stalled while the window is registered, the sum is scaled, 19 restoring
// division steps run (one quotient bit per cycle) and the result is handed to the
// output register, which then holds it while the next frames come in. While the
// output register is still full and stalled, the hand-over waits, and the input
// stays stalled for as long as that lasts.
// Configuration registers: rate_select at byte address 0, stereo_enable at 4.
module stereo_box_decimator_to_pcm16 #(
  parameter int SampleBits = sbd_pkg::SampleBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sbd_pkg::PaddrW-1:0]   paddr,
  input  logic [sbd_pkg::PdataW-1:0]   pwdata,
  output logic [sbd_pkg::PdataW-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [SampleBits-1:0] left_sample_i,
  input  logic signed [SampleBits-1:0] right_sample_i,
  input  logic                         last_in_block_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [sbd_pkg::PcmW-1:0] pcm_out_o
);
  import sbd_pkg::*;

  sbd_cfg_t                     cfg_q;
  sbd_close_t                   close;
  logic signed [SampleBits+2:0] close_sum;
  logic                         in_accept;
  logic                         div_busy, div_valid, div_take;
  logic [PcmW-1:0]              div_pcm;
  logic                         out_valid_q;
  logic [PcmW-1:0]              pcm_q;
  logic                         cfg_write;

  // Register file writes.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_select   <= 1'b0;
      cfg_q.stereo_enable <= 1'b1;
    end else if (cfg_write) begin
      case (paddr[2])
        RegRateSelect:   cfg_q.rate_select   <= pwdata[0];
        RegStereoEnable: cfg_q.stereo_enable <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Register file reads; unaligned addresses read as zero.
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (paddr[2])
        RegRateSelect:   prdata = PdataW'(cfg_q.rate_select);
        RegStereoEnable: prdata = PdataW'(cfg_q.stereo_enable);
        default:         prdata = '0;
      endcase
    end
  end

  // The input waits while a closed window is divided and handed on.
  assign in_stall_o = close.valid || div_busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  sbd_window #(
    .SampleBits(SampleBits)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .accept_i(in_accept),
    .left_i  (left_sample_i),
    .right_i (right_sample_i),
    .last_i  (last_in_block_i),
    .close_o (close),
    .sum_o   (close_sum)
  );

  sbd_serial_div #(
    .SampleBits(SampleBits)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .close_i(close),
    .sum_i  (close_sum),
    .take_i (div_take),
    .busy_o (div_busy),
    .valid_o(div_valid),
    .pcm_o  (div_pcm)
  );

  // Output register: loads when empty or when its transfer completes.
  assign div_take = div_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_take) begin
      pcm_q <= div_pcm;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pcm_out_o   = pcm_q;

endmodule

[src/sbd_window.sv]
`include "stereo_box_decimator_to_pcm16_macros.svh"

module sbd_window #(
  parameter int SampleBits = sbd_pkg::SampleBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sbd_pkg::sbd_cfg_t        cfg_i,
  input  logic                     accept_i,
  input  logic signed [SampleBits-1:0] left_i,
  input  logic signed [SampleBits-1:0] right_i,
  input  logic                     last_i,
  output sbd_pkg::sbd_close_t      close_o,
  output logic signed [SampleBits+2:0] sum_o
);
  import sbd_pkg::*;

  localparam int SumW = SampleBits + 3;

  logic signed [SumW-1:0] sum_q, sum_d, sum_add;
  logic [CountW-1:0]      count_q, count_d, count_add;
  logic [CreditW-1:0]     credit_q, credit_d, credit_dec, rate;
  logic                   emit;
  sbd_close_t             close_q, close_d;
  logic signed [SumW-1:0] close_sum_q;

  // Frame sum, frame count and credit after taking this frame.
  always_comb begin
    rate       = cfg_i.rate_select ? RateHighC : RateLowC;
    sum_add    = sum_q + SumW'(left_i) + (cfg_i.stereo_enable ? SumW'(right_i) : '0);
    count_add  = count_q + CountW'(1);
    credit_dec = (credit_q >= OutRateC) ? (credit_q - OutRateC) : '0;
    emit       = credit_dec < OutRateC;
  end

  // Window edge and block end handling.
  always_comb begin
    sum_d    = sum_q;
    count_d  = count_q;
    credit_d = credit_q;
    close_d.valid   = accept_i && emit;
    close_d.samples = cfg_i.stereo_enable ? {count_add[SamplesW-2:0], 1'b0} : count_add;
    if (accept_i) begin
      if (emit) begin
        sum_d    = '0;
        count_d  = '0;
        credit_d = credit_dec + rate;
      end else begin
        sum_d    = sum_add;
        count_d  = count_add;
        credit_d = credit_dec;
      end
      if (last_i) begin
        sum_d    = '0;
        count_d  = '0;
        credit_d = rate;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      count_q  <= '0;
      credit_q <= RateLowC;
      close_q  <= '0;
    end else begin
      sum_q    <= sum_d;
      count_q  <= count_d;
      credit_q <= credit_d;
      close_q  <= close_d;
    end
  end

  // The closed window's sum waits here for the divider.
  always_ff @(posedge clk_i) begin
    if (accept_i && emit) begin
      close_sum_q <= sum_add;
    end
  end

  assign close_o = close_q;
  assign sum_o   = close_sum_q;

  `SBD_ASSERT_IMP(a_credit_bound, clk_i, rst_ni, 1'b1, credit_q < CreditLimitC)
  `SBD_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CountMaxC)
  `SBD_ASSERT_NEXT(a_close_clears, clk_i, rst_ni, accept_i && emit, count_q == '0 && sum_q == '0)

endmodule

[src/sbd_serial_div.sv]
`include "stereo_box_decimator_to_pcm16_macros.svh"

module sbd_serial_div #(
  parameter int SampleBits = sbd_pkg::SampleBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sbd_pkg::sbd_close_t          close_i,
  input  logic signed [SampleBits+2:0] sum_i,
  input  logic                         take_i,
  output logic                         busy_o,
  output logic                         valid_o,
  output logic [sbd_pkg::PcmW-1:0]     pcm_o
);
  import sbd_pkg::*;

  localparam int SumW  = SampleBits + 3;
  localparam int ProdW = SumW + FullScaleShift;
  localparam int CntW  = $clog2(QuotW);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScale = 2'd1;
  localparam logic [1:0] StRun   = 2'd2;
  localparam logic [1:0] StHold  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [SumW-1:0]     mag_q;
  logic                neg_q;
  logic [SamplesW-1:0] div_q;
  logic [QuotW-1:0]    shreg_q;
  logic [SamplesW-1:0] rem_q;
  logic [ProdW-1:0]    prod;
  logic [SamplesW:0]   trial, trial_sub;
  logic                fits;

  // Scale by 32767, then keep the bits above the Q1.x fraction.
  assign prod = {mag_q, {FullScaleShift{1'b0}}} - {{FullScaleShift{1'b0}}, mag_q};

  // One restoring division step: bring down the next dividend bit.
  always_comb begin
    trial     = {rem_q, shreg_q[QuotW-1]};
    trial_sub = trial - {1'b0, div_q};
    fits      = trial >= {1'b0, div_q};
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (close_i.valid) begin
          state_d = StScale;
        end
      end
      StScale: begin
        state_d = StRun;
        cnt_d   = '0;
      end
      StRun: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(QuotW - 1)) begin
          state_d = StHold;
        end
      end
      StHold: begin
        if (take_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath: magnitude, scaled dividend, then one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (close_i.valid) begin
          mag_q <= sum_i[SumW-1] ? SumW'(-sum_i) : SumW'(sum_i);
          neg_q <= sum_i[SumW-1];
          div_q <= close_i.samples;
        end
      end
      StScale: begin
        shreg_q <= prod[SampleBits-1 +: QuotW];
        rem_q   <= '0;
      end
      StRun: begin
        rem_q   <= fits ? trial_sub[SamplesW-1:0] : trial[SamplesW-1:0];
        shreg_q <= {shreg_q[QuotW-2:0], fits};
      end
      default: begin
      end
    endcase
  end

  // Sign and saturation of the truncated quotient.
  always_comb begin
    if (neg_q) begin
      pcm_o = (shreg_q > QuotW'(32768)) ? PcmMinC : PcmW'(~shreg_q[PcmW-1:0] + PcmW'(1));
    end else begin
      pcm_o = (shreg_q > QuotW'(32767)) ? PcmMaxC : shreg_q[PcmW-1:0];
    end
  end

  assign busy_o  = state_q != StIdle;
  assign valid_o = state_q == StHold;

  `SBD_ASSERT_NEXT(a_start_scales, clk_i, rst_ni, state_q == StIdle && close_i.valid, state_q == StScale)
  `SBD_ASSERT_IMP(a_no_start_busy, clk_i, rst_ni, close_i.valid, state_q == StIdle)
  `SBD_ASSERT_NEXT(a_run_ends, clk_i, rst_ni, state_q == StRun && cnt_q == CntW'(QuotW - 1), state_q == StHold)

endmodule

[bench/stereo_box_decimator_to_pcm16_test.sv]
module stereo_box_decimator_to_pcm16_test;

  localparam int SampleW = sbd_pkg::SampleBitsDef;
  localparam int PcmW = sbd_pkg::PcmW;

  // Register map of the configuration port.
  localparam logic [sbd_pkg::PaddrW-1:0] RateAddr   = 3'd0;
  localparam logic [sbd_pkg::PaddrW-1:0] StereoAddr = 3'd4;

  // Rates in Hz and credit arithmetic.
  localparam int OutHz     = 16000;
  localparam int LowHz     = 44100;
  localparam int HighHz    = 48000;
  localparam int CreditMsk = 'h1FFFF;
  localparam longint PcmMax = 32767;
  localparam longint PcmMin = -32768;

  // Window closes stall the input; leave margin before touching registers.
  localparam int DrainCycles = 40;
  localparam int PhaseFrames = 80;
  localparam int PhaseCount  = 9;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [PcmW-1:0] pcm_t;

  localparam sample_t SampleMax = sample_t'(8388607);
  localparam sample_t SampleMin = sample_t'(-8388608);

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [sbd_pkg::PaddrW-1:0] paddr;
  logic [sbd_pkg::PdataW-1:0] pwdata;
  logic [sbd_pkg::PdataW-1:0] prdata;
  logic pready;
  logic in_valid_i;
  logic in_stall_o;
  sample_t left_sample_i;
  sample_t right_sample_i;
  logic last_in_block_i;
  logic out_valid_o;
  logic out_stall_i;
  pcm_t pcm_out_o;

  stereo_box_decimator_to_pcm16 dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .last_in_block_i(last_in_block_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pcm_out_o      (pcm_out_o)
  );

  // Decimator state as the bench predicts it.
  logic   cfg_rate_high;
  logic   cfg_stereo;
  longint win_sum;
  int     win_frames;
  int     credit;

  pcm_t pcm_expected[$];

  int  errors;
  int  frames_sent;
  int  pcm_checked;
  int  reg_writes;
  int  stall_run;
  bit  no_idle;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return SampleMax;
    if (r < 20) return SampleMin;
    if (r < 25) return '0;
    if (r < 30) return '1;
    if (r < 45) return sample_t'($signed($urandom_range(0, 2047)) - 1024);
    return sample_t'($urandom);
  endfunction

  function automatic int rate_hz();
    return cfg_rate_high ? HighHz : LowHz;
  endfunction

  // Average of a window scaled to int16, truncated toward zero and clamped.
  function automatic pcm_t scale_to_pcm(longint sum, int samples);
    longint den;
    longint q;
    den = longint'(samples) * (longint'(1) << (SampleW - 1));
    if (den <= 0) return '0;
    q = (sum * 32767) / den;
    if (q > PcmMax) q = PcmMax;
    if (q < PcmMin) q = PcmMin;
    return pcm_t'(q);
  endfunction

  // Advance the predicted state by one frame and queue the sample it emits.
  task automatic predict_frame(input sample_t l, input sample_t r, input logic last_flag);
    int samples;
    win_sum += l;
    if (cfg_stereo) win_sum += r;
    win_frames = (win_frames + 1) & 7;
    if (credit >= OutHz) credit -= OutHz;
    else credit = 0;
    if (credit < OutHz) begin
      samples = cfg_stereo ? win_frames * 2 : win_frames;
      pcm_expected.push_back(scale_to_pcm(win_sum, samples));
      win_sum = 0;
      win_frames = 0;
      credit = (credit + rate_hz()) & CreditMsk;
    end
    if (last_flag) begin
      win_sum = 0;
      win_frames = 0;
      credit = rate_hz();
    end
  endtask

  // Present one frame after a random gap and hold it until the transfer.
  task automatic send_frame(input sample_t l, input sample_t r, input logic last_flag);
    int gap;
    gap = no_idle ? 0 : idle_length();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_sample_i <= l;
    right_sample_i <= r;
    last_in_block_i <= last_flag;
    do @(posedge clk_i); while (in_stall_o);
    predict_frame(l, r, last_flag);
    frames_sent++;
  endtask

  // Stop sending, let every expected sample arrive, then let the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pcm_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One write through the setup and access cycles; only bit 0 is meaningful.
  task automatic write_reg(input logic [sbd_pkg::PaddrW-1:0] addr,
                           input logic [sbd_pkg::PdataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == RateAddr) cfg_rate_high = data[0];
    else if (addr == StereoAddr) cfg_stereo = data[0];
    reg_writes++;
  endtask

  task automatic configure(input logic rate_high, input logic stereo);
    logic [sbd_pkg::PdataW-1:0] v;
    drain();
    v = $urandom;
    v[0] = rate_high;
    write_reg(RateAddr, v);
    v = $urandom;
    v[0] = stereo;
    write_reg(StereoAddr, v);
  endtask

  // Full-scale frames in stereo at 44.1 kHz, ending in a dropped partial window.
  task automatic check_full_scale_windows();
    send_frame(SampleMax, SampleMax, 1'b0);
    send_frame(SampleMax, SampleMax, 1'b0);
    send_frame(SampleMin, SampleMin, 1'b0);
    send_frame(SampleMin, SampleMin, 1'b0);
    send_frame(SampleMin, SampleMax, 1'b0);
    send_frame(sample_t'(0), sample_t'(-1), 1'b1);
  endtask

  // Block ends on a lone frame and on a frame that closes a window.
  task automatic check_block_end_drop();
    send_frame(SampleMax, SampleMin, 1'b1);
    send_frame(sample_t'(1), sample_t'(-1), 1'b0);
    send_frame(SampleMax, sample_t'(0), 1'b1);
    send_frame(sample_t'(-1), SampleMin, 1'b1);
  endtask

  // Left channel only: the right sample must not reach the sum.
  task automatic check_left_only();
    configure(1'b0, 1'b0);
    send_frame(SampleMax, SampleMin, 1'b0);
    send_frame(SampleMax, SampleMin, 1'b0);
    send_frame(SampleMin, SampleMax, 1'b0);
    send_frame(SampleMin, SampleMax, 1'b1);
  endtask

  // At 48 kHz after a 44.1 kHz block end, the first window takes two frames.
  task automatic check_high_rate();
    configure(1'b1, 1'b1);
    send_frame(SampleMax, SampleMax, 1'b0);
    send_frame(SampleMax, SampleMin, 1'b0);
    send_frame(SampleMin, SampleMin, 1'b0);
    send_frame(sample_t'(12345), sample_t'(-54321), 1'b1);
  endtask

  // A rate change inside a block acts only at the next window edge.
  task automatic check_rate_switch_mid_block();
    configure(1'b0, 1'b1);
    send_frame(sample_t'(1000), sample_t'(2000), 1'b0);
    send_frame(sample_t'(-3000), sample_t'(4000), 1'b0);
    send_frame(SampleMax, sample_t'(5), 1'b0);
    drain();
    write_reg(RateAddr, 32'hA5A5_5A5B);
    send_frame(SampleMin, sample_t'(7), 1'b0);
    send_frame(sample_t'(-8), SampleMax, 1'b0);
    send_frame(sample_t'(9), sample_t'(10), 1'b1);
  endtask

  // The divisor follows stereo at window close; here the block end drops the window.
  task automatic check_stereo_switch_mid_window();
    configure(1'b0, 1'b1);
    send_frame(sample_t'(4000000), SampleMax, 1'b0);
    drain();
    write_reg(StereoAddr, 32'hFFFF_FFFE);
    send_frame(sample_t'(-4000000), SampleMin, 1'b1);
  endtask

  // Phases of random blocks under every register setting, extremes first.
  task automatic check_random_traffic();
    int blk_left;
    logic rate_high;
    logic stereo;
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin
          rate_high = 1'b0;
          stereo = 1'b0;
        end
        1: begin
          rate_high = 1'b1;
          stereo = 1'b1;
        end
        2: begin
          rate_high = 1'b1;
          stereo = 1'b0;
        end
        3: begin
          rate_high = 1'b0;
          stereo = 1'b1;
        end
        default: begin
          rate_high = 1'($urandom_range(0, 1));
          stereo = 1'($urandom_range(0, 1));
        end
      endcase
      configure(rate_high, stereo);
      // One phase runs with no gaps on either side.
      no_idle = (p == 4);
      blk_left = 0;
      for (int i = 0; i < PhaseFrames; i++) begin
        if (blk_left == 0) begin
          blk_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                 : $urandom_range(4, 40);
        end
        blk_left--;
        send_frame(rand_sample(), rand_sample(), blk_left == 0);
      end
      no_idle = 1'b0;
    end
  endtask

  // Output side: random stalls, and each transfer checked against the oldest prediction.
  always @(posedge clk_i) begin
    pcm_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pcm_expected.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected pcm_out_o %0d", pcm_out_o);
        end else begin
          want = pcm_expected.pop_front();
          pcm_checked++;
          if (pcm_out_o !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("pcm_out_o mismatch: expected %0d, got %0d", want, pcm_out_o);
            end
          end
        end
      end
      if (stall_run == 0 && $urandom_range(0, 3) == 0) stall_run = idle_length();
      out_stall_i <= !no_idle && stall_run > 0;
      if (stall_run > 0) stall_run--;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid_i <= 1'b0;
    left_sample_i <= '0;
    right_sample_i <= '0;
    last_in_block_i <= 1'b0;
    out_stall_i <= 1'b0;
    errors = 0;
    frames_sent = 0;
    pcm_checked = 0;
    reg_writes = 0;
    stall_run = 0;
    no_idle = 1'b0;
    cfg_rate_high = 1'b0;
    cfg_stereo = 1'b1;
    win_sum = 0;
    win_frames = 0;
    credit = LowHz;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_full_scale_windows();
    check_block_end_drop();
    check_left_only();
    check_high_rate();
    check_rate_switch_mid_block();
    check_stereo_switch_mid_window();
    check_random_traffic();
    drain();

    $display("sent %0d frames and checked %0d pcm samples", frames_sent, pcm_checked);
    $display("used %0d register writes across both rates and channel modes", reg_writes);
    if (errors == 0) begin
      $display("stereo_box_decimator_to_pcm16_test: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("stereo_box_decimator_to_pcm16_test: done, errors");
    end
    $finish;
  end

  // Safety net in case a handshake never completes.
  initial begin
    #2000000;
    $display("timed out with %0d pcm samples outstanding", pcm_expected.size());
    $display("stereo_box_decimator_to_pcm16_test: done, errors");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/sbd_pkg.sv
src/sbd_window.sv
src/sbd_serial_div.sv
src/stereo_box_decimator_to_pcm16.sv
bench/stereo_box_decimator_to_pcm16_test.sv
